// ===== hw/rtl/rfc_pkg.sv =====
// Shared constants, node entry layout and state type of the random forest classifier.
`timescale 1ns / 1ps

package rfc_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_TREES_DEF      = 16;
    localparam int NODES_PER_TREE_DEF = 1024;
    localparam int NUM_FEATURES_DEF   = 64;
    localparam int MAX_DEPTH_DEF      = 64;

    // Fixed field widths
    localparam int OP_W     = 2;
    localparam int TIDX_W   = 4;
    localparam int NIDX_W   = 10;
    localparam int FID_W    = 6;
    localparam int VAL_W    = 16;
    localparam int CHILD_W  = 10;
    localparam int PROB_W   = 16;
    localparam int TC_W     = 5;
    localparam int ENTRY_W  = 64;

    // Probability sums over at most 31 trees
    localparam int SUM_W    = PROB_W + TC_W;

    // Fraction bits of the reciprocal used to wrap child indexes
    localparam int RECIP_SHIFT = 20;

    // Operation codes
    localparam logic [OP_W-1:0] OP_LOAD_NODE = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_FEAT = 2'd1;
    localparam logic [OP_W-1:0] OP_CLASSIFY  = 2'd2;

    // Node entry layout
    localparam int FEAT_LSB  = 0;
    localparam int THR_LSB   = 6;
    localparam int CHILD_LSB = 22;
    localparam int P1_LSB    = 32;
    localparam int P2_LSB    = 48;

    typedef enum logic [2:0] {
        S_IDLE,
        S_NODE,
        S_FEAT,
        S_WRAP_Q,
        S_WRAP_R,
        S_DIV
    } t_state;

endpackage

// ===== hw/rtl/random_forest_classifier_top.sv =====
// Random forest classifier: node table, feature store, tree walker and mean divider.
//
// A load item (node entry or feature sample) is written without raising busy.
// A classify item walks the first tree_count trees (0 reads as 1, values above
// MAX_TREES saturate) through the single-port node table and feature store, both
// with a registered read. Each move of a tree reads the node entry, then the
// feature, and a move whose child index lies beyond the tree is then wrapped
// through a quotient step and a remainder step. After the last tree a
// bit-serial divider takes the mean of both probability sums over the trees.
// busy is high for the whole walk; the
// result appears on o_valid for exactly one cycle and cannot be held off, so the
// receiver must take it then. Loads are refused while busy, so table writes never
// overlap a walk. The node table and feature store power up undefined: load every
// entry a walk can reach before classifying.
`timescale 1ns / 1ps

module random_forest_classifier_top #(
    parameter int MAX_TREES      = rfc_pkg::MAX_TREES_DEF,
    parameter int NODES_PER_TREE = rfc_pkg::NODES_PER_TREE_DEF,
    parameter int NUM_FEATURES   = rfc_pkg::NUM_FEATURES_DEF,
    parameter int MAX_DEPTH      = rfc_pkg::MAX_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [rfc_pkg::OP_W-1:0]          i_op,
    input  logic [rfc_pkg::TIDX_W-1:0]        i_tree_index,
    input  logic [rfc_pkg::NIDX_W-1:0]        i_node_index,
    input  logic [rfc_pkg::FID_W-1:0]         i_split_feature,
    input  logic signed [rfc_pkg::VAL_W-1:0]  i_split_threshold,
    input  logic [rfc_pkg::CHILD_W-1:0]       i_right_child,
    input  logic [rfc_pkg::PROB_W-1:0]        i_leaf_prob_first,
    input  logic [rfc_pkg::PROB_W-1:0]        i_leaf_prob_second,
    input  logic [rfc_pkg::FID_W-1:0]         i_feature_slot,
    input  logic signed [rfc_pkg::VAL_W-1:0]  i_feature_value,
    input  logic                              i_cfg_we,
    input  logic [rfc_pkg::TC_W-1:0]          i_cfg_wdata,
    output logic                              o_valid,
    output logic [rfc_pkg::PROB_W-1:0]        o_prob_first,
    output logic [rfc_pkg::PROB_W-1:0]        o_prob_second,
    output logic                              o_walk_overrun
);

    import rfc_pkg::*;

    localparam int TREE_W  = (MAX_TREES > 1) ? $clog2(MAX_TREES) : 1;
    localparam int NODE_W  = $clog2(NODES_PER_TREE);
    localparam int ADDR_W  = TREE_W + NODE_W;
    localparam int FEAT_W  = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
    localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
    localparam int RECIP   = (1 << RECIP_SHIFT) / NODES_PER_TREE;
    localparam int PROD_W  = CHILD_W + RECIP_SHIFT;
    localparam int QN_W    = CHILD_W + NODE_W + 1;

    // Storage
    logic [ENTRY_W-1:0] r_node_mem [1 << ADDR_W];
    logic [VAL_W-1:0]   r_feat_mem [1 << FEAT_W];

    // Control and datapath registers
    t_state               r_state, n_state;
    logic [TC_W-1:0]      r_tree_count;
    logic [TC_W-1:0]      r_eff;
    logic [TREE_W-1:0]    r_tree;
    logic [DEPTH_W-1:0]   r_moves;
    logic [ENTRY_W-1:0]   r_node_q;
    logic [VAL_W-1:0]     r_feat_q;
    logic                 r_feat_ok;
    logic [CHILD_W-1:0]   r_next;
    logic [CHILD_W-1:0]   r_quot;
    logic [SUM_W-1:0]     r_sum1, r_sum2;
    logic [TC_W-1:0]      r_rem1, r_rem2;
    logic [TC_W-1:0]      r_div_cnt;
    logic                 r_overrun;
    logic                 r_valid;
    logic [PROB_W-1:0]    r_prob_first, r_prob_second;
    logic                 r_walk_overrun;

    // Combinational signals
    logic                 w_accept;
    logic [TC_W-1:0]      w_eff_in;
    logic [FID_W-1:0]     w_feat_id;
    logic signed [VAL_W-1:0] w_thr;
    logic signed [VAL_W-1:0] w_fv;
    logic [CHILD_W-1:0]   w_child;
    logic [PROB_W-1:0]    w_p1, w_p2;
    logic                 w_leaf, w_stop, w_last_tree, w_lt, w_next_in;
    logic [CHILD_W-1:0]   w_next;
    logic [TREE_W-1:0]    w_tree_inc;
    logic [PROD_W-1:0]    w_prod;
    logic [CHILD_W-1:0]   w_quot;
    logic [QN_W-1:0]      w_qn, w_rem0, w_rem;
    logic [SUM_W-1:0]     w_add1, w_add2;
    logic [TC_W:0]        w_t1, w_t2, w_r1, w_r2;
    logic                 w_ge1, w_ge2, w_div_last;
    logic [SUM_W-1:0]     w_q1, w_q2;
    logic                 w_node_we, w_node_re, w_feat_we, w_feat_re;
    logic [ADDR_W-1:0]    w_node_waddr, w_node_raddr;
    logic [FEAT_W-1:0]    w_feat_waddr, w_feat_raddr;
    logic [ENTRY_W-1:0]   w_entry;

    assign w_accept = start && (r_state == S_IDLE);

    // Clamp the tree count to the loaded range
    always_comb begin
        if (i_cfg_we == 1'b0 && r_tree_count == '0) begin
            w_eff_in = TC_W'(1);
        end else if (r_tree_count == '0) begin
            w_eff_in = TC_W'(1);
        end else if (32'(r_tree_count) > MAX_TREES) begin
            w_eff_in = TC_W'(MAX_TREES);
        end else begin
            w_eff_in = r_tree_count;
        end
    end

    // Decode the node under the walk
    assign w_feat_id   = r_node_q[FEAT_LSB +: FID_W];
    assign w_thr       = $signed(r_node_q[THR_LSB +: VAL_W]);
    assign w_child     = r_node_q[CHILD_LSB +: CHILD_W];
    assign w_p1        = r_node_q[P1_LSB +: PROB_W];
    assign w_p2        = r_node_q[P2_LSB +: PROB_W];
    assign w_leaf      = (w_child == '0);
    assign w_stop      = w_leaf || (r_moves == DEPTH_W'(MAX_DEPTH));
    assign w_last_tree = ((32'(r_tree) + 32'd1) == 32'(r_eff));
    assign w_tree_inc  = r_tree + 1'b1;

    // Compare and pick the child
    assign w_fv      = r_feat_ok ? $signed(r_feat_q) : '0;
    assign w_lt      = (w_fv < w_thr);
    assign w_next    = w_lt ? (w_child - 1'b1) : w_child;
    assign w_next_in = (32'(w_next) < NODES_PER_TREE);

    // Wrap an out-of-range child: reciprocal quotient, then one correction
    assign w_prod = PROD_W'(r_next) * PROD_W'(RECIP);
    assign w_quot = w_prod[PROD_W-1 -: CHILD_W];
    assign w_qn   = QN_W'(r_quot) * QN_W'(NODES_PER_TREE);
    assign w_rem0 = QN_W'(r_next) - w_qn;
    assign w_rem  = (w_rem0 >= QN_W'(NODES_PER_TREE)) ?
                    (w_rem0 - QN_W'(NODES_PER_TREE)) : w_rem0;

    // Accumulate leaf probabilities
    assign w_add1 = r_sum1 + SUM_W'(w_p1);
    assign w_add2 = r_sum2 + SUM_W'(w_p2);

    // One restoring division step per cycle on both sums
    assign w_t1       = {r_rem1, r_sum1[SUM_W-1]};
    assign w_t2       = {r_rem2, r_sum2[SUM_W-1]};
    assign w_ge1      = (w_t1 >= {1'b0, r_eff});
    assign w_ge2      = (w_t2 >= {1'b0, r_eff});
    assign w_r1       = w_ge1 ? (w_t1 - {1'b0, r_eff}) : w_t1;
    assign w_r2       = w_ge2 ? (w_t2 - {1'b0, r_eff}) : w_t2;
    assign w_q1       = {r_sum1[SUM_W-2:0], w_ge1};
    assign w_q2       = {r_sum2[SUM_W-2:0], w_ge2};
    assign w_div_last = (r_div_cnt == TC_W'(SUM_W - 1));

    // Pack a node entry from a load beat
    assign w_entry = {i_leaf_prob_second, i_leaf_prob_first, i_right_child,
                      i_split_threshold, i_split_feature};
    assign w_node_waddr = {TREE_W'(i_tree_index), NODE_W'(i_node_index)};
    assign w_feat_waddr = FEAT_W'(i_feature_slot);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && i_op == OP_CLASSIFY) begin
                    n_state = S_NODE;
                end
            end
            S_NODE: begin
                if (!w_stop) begin
                    n_state = S_FEAT;
                end else if (w_last_tree) begin
                    n_state = S_DIV;
                end
            end
            S_FEAT: begin
                n_state = w_next_in ? S_NODE : S_WRAP_Q;
            end
            S_WRAP_Q: begin
                n_state = S_WRAP_R;
            end
            S_WRAP_R: begin
                n_state = S_NODE;
            end
            S_DIV: begin
                if (w_div_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Memory port control
    always_comb begin
        w_node_we    = 1'b0;
        w_feat_we    = 1'b0;
        w_node_re    = 1'b0;
        w_feat_re    = 1'b0;
        w_node_raddr = {r_tree, NODE_W'(w_next)};
        w_feat_raddr = FEAT_W'(w_feat_id);
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    w_node_we = (i_op == OP_LOAD_NODE) &&
                                (32'(i_tree_index) < MAX_TREES) &&
                                (32'(i_node_index) < NODES_PER_TREE);
                    w_feat_we = (i_op == OP_LOAD_FEAT) &&
                                (32'(i_feature_slot) < NUM_FEATURES);
                    if (i_op == OP_CLASSIFY) begin
                        w_node_re    = 1'b1;
                        w_node_raddr = {TREE_W'(0), {NODE_W{1'b0}}};
                    end
                end
            end
            S_NODE: begin
                if (w_stop) begin
                    w_node_re    = !w_last_tree;
                    w_node_raddr = {w_tree_inc, {NODE_W{1'b0}}};
                end else begin
                    w_feat_re = 1'b1;
                end
            end
            S_FEAT: begin
                w_node_re = w_next_in;
            end
            S_WRAP_R: begin
                w_node_re    = 1'b1;
                w_node_raddr = {r_tree, w_rem[NODE_W-1:0]};
            end
            S_WRAP_Q, S_DIV: begin
            end
            default: begin
            end
        endcase
    end

    // Node table and feature store, registered read
    always_ff @(posedge i_clk) begin
        if (w_node_we) begin
            r_node_mem[w_node_waddr] <= w_entry;
        end
        if (w_node_re) begin
            r_node_q <= r_node_mem[w_node_raddr];
        end
        if (w_feat_we) begin
            r_feat_mem[w_feat_waddr] <= i_feature_value;
        end
        if (w_feat_re) begin
            r_feat_q <= r_feat_mem[w_feat_raddr];
        end
    end

    // Walk, accumulate and divide
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_tree_count <= TC_W'(1);
            r_valid      <= 1'b0;
            r_moves      <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= 1'b0;
            if (i_cfg_we) begin
                r_tree_count <= i_cfg_wdata;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept && i_op == OP_CLASSIFY) begin
                        r_eff     <= w_eff_in;
                        r_tree    <= '0;
                        r_moves   <= '0;
                        r_sum1    <= '0;
                        r_sum2    <= '0;
                        r_overrun <= 1'b0;
                    end
                end
                S_NODE: begin
                    if (w_stop) begin
                        r_sum1    <= w_add1;
                        r_sum2    <= w_add2;
                        r_tree    <= w_tree_inc;
                        r_moves   <= '0;
                        r_rem1    <= '0;
                        r_rem2    <= '0;
                        r_div_cnt <= '0;
                        if (!w_leaf) begin
                            r_overrun <= 1'b1;
                        end
                    end else begin
                        r_feat_ok <= (32'(w_feat_id) < NUM_FEATURES);
                    end
                end
                S_FEAT: begin
                    r_next <= w_next;
                    if (w_next_in) begin
                        r_moves <= r_moves + 1'b1;
                    end
                end
                S_WRAP_Q: begin
                    r_quot <= w_quot;
                end
                S_WRAP_R: begin
                    r_moves <= r_moves + 1'b1;
                end
                S_DIV: begin
                    r_sum1    <= w_q1;
                    r_sum2    <= w_q2;
                    r_rem1    <= w_r1[TC_W-1:0];
                    r_rem2    <= w_r2[TC_W-1:0];
                    r_div_cnt <= r_div_cnt + 1'b1;
                    if (w_div_last) begin
                        r_valid        <= 1'b1;
                        r_walk_overrun <= r_overrun;
                        r_prob_first   <= (|w_q1[SUM_W-1:PROB_W]) ? '1 : w_q1[PROB_W-1:0];
                        r_prob_second  <= (|w_q2[SUM_W-1:PROB_W]) ? '1 : w_q2[PROB_W-1:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_valid        = r_valid;
    assign o_prob_first   = r_prob_first;
    assign o_prob_second  = r_prob_second;
    assign o_walk_overrun = r_walk_overrun;

    // A result beat lasts one cycle
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held past one cycle");

    // A classify beat starts a walk
    a_classify_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_op == OP_CLASSIFY) |=> busy)
        else $error("classify accepted without starting a walk");

    // A load beat completes at once and gives no result
    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_op != OP_CLASSIFY) |=> (!busy && !o_valid))
        else $error("load beat left the block busy or produced a result");

    // The walk never moves past the depth bound
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NODE) |-> (r_moves <= DEPTH_W'(MAX_DEPTH)))
        else $error("tree walk moved past the depth bound");

endmodule
